/* design/ppm_pkg.sv */
// Shared types and constants of the plane PSNR meter.
package ppm_pkg;

    localparam int LANES       = 4;
    localparam int PIX_W       = 16;
    localparam int SQ_W        = 2 * PIX_W;
    localparam int SSE_W       = 63;
    localparam int PSNR_W      = 15;
    localparam int LOG_W       = 22;
    localparam int MAX_SAMPLE_BITS = 16;

    localparam logic [PSNR_W-1:0] PSNR_CAP = 15'd25600;
    // Ten times log10 of two in Q24.
    localparam logic [25:0] TEN_LOG10_2_Q24 = 26'd50504453;
    localparam logic [SSE_W-1:0] SSE_MAX = {SSE_W{1'b1}};

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SAMPLE_BITS  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix_a0;
        logic [PIX_W-1:0] pix_a1;
        logic [PIX_W-1:0] pix_a2;
        logic [PIX_W-1:0] pix_a3;
        logic [PIX_W-1:0] pix_b0;
        logic [PIX_W-1:0] pix_b1;
        logic [PIX_W-1:0] pix_b2;
        logic [PIX_W-1:0] pix_b3;
        logic [2:0]       lanes_valid;
        logic             frame_end;
    } ppm_item_t;

    typedef struct packed {
        logic [PSNR_W-1:0] psnr_q8;
        logic [SSE_W-1:0]  sse_total;
    } ppm_result_t;

    // Request to the shared log2 unit and its answer.
    typedef struct packed {
        logic        start;
        logic [63:0] x;
    } log_req_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } log_rsp_t;

endpackage

/* design/plane_psnr_meter.sv */
// Top level of the plane PSNR meter: lanes, SSE accumulator and PSNR sequencer.
//
// An item is a group of up to four pixel pairs; it is taken at a clock edge with
// start high and busy low. The first lanes_valid pairs are real (values above
// four count as four). Each lane registers the square of its difference, and
// the lane sum is then added to a 63-bit sum of squared errors that saturates
// at its top value. Items without frame_end are taken every cycle while busy
// is low. An item with frame_end raises busy from the next cycle until its
// result has been shown: the sum is latched and cleared, peak squared times
// width times height is formed in two multiply steps, and one shared log2 unit
// runs twice (a normalising shift, then one squaring step per fraction bit
// each), followed by a scaling multiply and rounding. A zero sum skips the
// logs and gives the PSNR cap; a zero peak product skips the logs and gives
// zero. The result is shown for exactly one cycle with result_valid high; the
// receiver cannot hold it off. Reset clears the sum and loads the default
// geometry of 1920 by 1080 at eight bits per sample.
module plane_psnr_meter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ppm_pkg::ppm_item_t   item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 result_valid,
    output ppm_pkg::ppm_result_t result
);
    import ppm_pkg::*;

    typedef enum logic [8:0] {
        T_IDLE    = 9'b000000001,
        T_MUL1    = 9'b000000010,
        T_MUL2    = 9'b000000100,
        T_LOGN_GO = 9'b000001000,
        T_LOGN    = 9'b000010000,
        T_LOGS    = 9'b000100000,
        T_SCALE   = 9'b001000000,
        T_ROUND   = 9'b010000000,
        T_OUT     = 9'b100000000
    } top_state_t;

    logic [15:0] width_reg, height_reg;
    logic [4:0]  bits_reg;

    logic [PIX_W-1:0] pix_a [LANES];
    logic [PIX_W-1:0] pix_b [LANES];
    logic [SQ_W-1:0]  sq [LANES];
    logic             accept;
    logic             s1_valid_reg, s1_end_reg;

    logic [SQ_W+1:0]  lane_sum;
    logic [SSE_W:0]   acc_wide;
    logic [SSE_W-1:0] acc_sat;
    logic [SSE_W-1:0] acc_reg;
    logic [SSE_W-1:0] sse_reg;

    top_state_t        state_reg, state_next;
    logic [4:0]        bits_c;
    logic [16:0]       maxval_w;
    logic [15:0]       maxval;
    logic [31:0]       msq_reg, wh_reg;
    logic [63:0]       n_reg;
    logic [LOG_W-1:0]  ln_reg;
    logic [LOG_W-1:0]  d_reg;
    logic [47:0]       prod_reg;
    logic [48:0]       rounded;
    logic [PSNR_W-1:0] psnr_reg, psnr_next;
    log_req_t          log_req;
    log_rsp_t          log_rsp;

    assign accept = start && !busy;

    assign pix_a[0] = item.pix_a0;
    assign pix_a[1] = item.pix_a1;
    assign pix_a[2] = item.pix_a2;
    assign pix_a[3] = item.pix_a3;
    assign pix_b[0] = item.pix_b0;
    assign pix_b[1] = item.pix_b1;
    assign pix_b[2] = item.pix_b2;
    assign pix_b[3] = item.pix_b3;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        ppm_lane u_lane (
            .clk     (clk),
            .pix_a   (pix_a[k]),
            .pix_b   (pix_b[k]),
            .lane_en (accept && (3'(k) < item.lanes_valid)),
            .sq      (sq[k])
        );
    end

    // Merge of the lane squares; all terms are non-negative, so one clamp
    // at the end matches saturating after every pair.
    assign lane_sum = (SQ_W+2)'(sq[0]) + (SQ_W+2)'(sq[1])
                    + (SQ_W+2)'(sq[2]) + (SQ_W+2)'(sq[3]);
    assign acc_wide = {1'b0, acc_reg} + (SSE_W+1)'(lane_sum);
    assign acc_sat  = acc_wide[SSE_W] ? SSE_MAX : acc_wide[SSE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 16'd1920;
            height_reg <= 16'd1080;
            bits_reg   <= 5'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                REG_SAMPLE_BITS:  bits_reg   <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_end_reg   <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_end_reg   <= accept && item.frame_end;
            if (s1_valid_reg)
            begin
                acc_reg <= s1_end_reg ? '0 : acc_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_end_reg)
        begin
            sse_reg <= acc_sat;
        end
    end

    assign bits_c   = (bits_reg > 5'(MAX_SAMPLE_BITS)) ? 5'(MAX_SAMPLE_BITS) : bits_reg;
    assign maxval_w = (17'd1 << bits_c) - 17'd1;
    assign maxval   = maxval_w[15:0];
    assign rounded  = {1'b0, prod_reg} + (49'd1 << 31);

    always_comb
    begin
        state_next    = state_reg;
        psnr_next     = psnr_reg;
        log_req.start = 1'b0;
        log_req.x     = (state_reg == T_LOGN_GO) ? n_reg : {1'b0, sse_reg};
        unique case (state_reg)
            T_IDLE:
            begin
                if (s1_valid_reg && s1_end_reg)
                begin
                    state_next = T_MUL1;
                end
            end
            T_MUL1:
            begin
                if (sse_reg == '0)
                begin
                    psnr_next  = PSNR_CAP;
                    state_next = T_OUT;
                end
                else
                begin
                    state_next = T_MUL2;
                end
            end
            T_MUL2:
            begin
                state_next = T_LOGN_GO;
            end
            T_LOGN_GO:
            begin
                if (n_reg == '0)
                begin
                    psnr_next  = '0;
                    state_next = T_OUT;
                end
                else
                begin
                    log_req.start = 1'b1;
                    state_next    = T_LOGN;
                end
            end
            T_LOGN:
            begin
                if (log_rsp.done)
                begin
                    log_req.start = 1'b1;
                    state_next    = T_LOGS;
                end
            end
            T_LOGS:
            begin
                if (log_rsp.done)
                begin
                    if (ln_reg <= log_rsp.value)
                    begin
                        psnr_next  = '0;
                        state_next = T_OUT;
                    end
                    else
                    begin
                        state_next = T_SCALE;
                    end
                end
            end
            T_SCALE:
            begin
                state_next = T_ROUND;
            end
            T_ROUND:
            begin
                if (rounded[48:32] > 17'(PSNR_CAP))
                begin
                    psnr_next = PSNR_CAP;
                end
                else
                begin
                    psnr_next = rounded[46:32];
                end
                state_next = T_OUT;
            end
            T_OUT:
            begin
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        psnr_reg <= psnr_next;
        if (state_reg == T_MUL1)
        begin
            msq_reg <= 32'(maxval) * 32'(maxval);
            wh_reg  <= 32'(width_reg) * 32'(height_reg);
        end
        if (state_reg == T_MUL2)
        begin
            n_reg <= 64'(msq_reg) * 64'(wh_reg);
        end
        if (state_reg == T_LOGN && log_rsp.done)
        begin
            ln_reg <= log_rsp.value;
        end
        if (state_reg == T_LOGS && log_rsp.done)
        begin
            d_reg <= ln_reg - log_rsp.value;
        end
        if (state_reg == T_SCALE)
        begin
            prod_reg <= 48'(d_reg) * 48'(TEN_LOG10_2_Q24);
        end
    end

    ppm_log2 u_log2 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    assign busy             = s1_end_reg || (state_reg != T_IDLE);
    assign result_valid     = (state_reg == T_OUT);
    assign result.psnr_q8   = psnr_reg;
    assign result.sse_total = sse_reg;

    a_end_raises_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.frame_end) |=> busy)
        else $error("frame end request did not raise busy");

    a_result_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_result_capped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.psnr_q8 <= PSNR_CAP))
        else $error("PSNR above cap");

    a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result shown while idle");

endmodule

/* design/ppm_lane.sv */
// One lane: registered square of the absolute pixel difference.
module ppm_lane (
    input  logic                     clk,
    input  logic [ppm_pkg::PIX_W-1:0] pix_a,
    input  logic [ppm_pkg::PIX_W-1:0] pix_b,
    input  logic                     lane_en,
    output logic [ppm_pkg::SQ_W-1:0]  sq
);
    import ppm_pkg::*;

    logic [PIX_W-1:0] diff;
    logic [SQ_W-1:0]  sq_reg;
    logic [SQ_W-1:0]  sq_next;

    assign diff    = (pix_a > pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
    assign sq_next = lane_en ? (SQ_W'(diff) * SQ_W'(diff)) : '0;

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign sq = sq_reg;

endmodule

/* design/ppm_log2.sv */
// Iterative log2 in Q16: normalising shift, then one squaring per fraction bit.
module ppm_log2 (
    input  logic                clk,
    input  logic                rst_n,
    input  ppm_pkg::log_req_t   req,
    output ppm_pkg::log_rsp_t   rsp
);
    import ppm_pkg::*;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_NORM = 4'b0010,
        L_SQ   = 4'b0100,
        L_STEP = 4'b1000
    } log_state_t;

    log_state_t  state_reg, state_next;
    logic [63:0] norm_reg, norm_next;
    logic [5:0]  p_reg, p_next;
    logic [31:0] m_reg, m_next;
    logic [63:0] prod_reg, prod_next;
    logic [15:0] frac_reg, frac_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [32:0] scaled;

    assign scaled = prod_reg[63:31];

    always_comb
    begin
        state_next = state_reg;
        norm_next  = norm_reg;
        p_next     = p_reg;
        m_next     = m_reg;
        prod_next  = prod_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            L_IDLE:
            begin
                if (req.start)
                begin
                    norm_next  = req.x;
                    p_next     = 6'd63;
                    state_next = L_NORM;
                end
            end
            L_NORM:
            begin
                if (norm_reg[63])
                begin
                    m_next     = norm_reg[63:32];
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = L_SQ;
                end
                else
                begin
                    norm_next = {norm_reg[62:0], 1'b0};
                    p_next    = p_reg - 6'd1;
                end
            end
            L_SQ:
            begin
                prod_next  = 64'(m_reg) * 64'(m_reg);
                state_next = L_STEP;
            end
            L_STEP:
            begin
                if (scaled[32])
                begin
                    frac_next = {frac_reg[14:0], 1'b1};
                    m_next    = scaled[32:1];
                end
                else
                begin
                    frac_next = {frac_reg[14:0], 1'b0};
                    m_next    = scaled[31:0];
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
                else
                begin
                    state_next = L_SQ;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
        p_reg    <= p_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        frac_reg <= frac_next;
        cnt_reg  <= cnt_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = {p_reg, frac_reg};

endmodule

/* tb/ppm_checker.sv */
// Checker of the plane PSNR meter: predicts each frame result and compares it.
module ppm_checker
    import ppm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  ppm_item_t   item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        result_valid,
    input  ppm_result_t result,
    output int          fail_count,
    output int          pending
);

    logic [15:0]      width_q;
    logic [15:0]      height_q;
    logic [4:0]       bits_q;
    logic [SSE_W-1:0] sse_sum;
    ppm_result_t      frame_results[$];

    assign pending = frame_results.size();

    // Base-two logarithm in Q16 by repeated squaring of the normalised mantissa.
    function automatic logic [LOG_W-1:0] log2_q16(input logic [63:0] x);
        int          p;
        logic [63:0] m;
        logic [15:0] frac;
        p = 0;
        frac = '0;
        for (int i = 0; i < 64; i++)
            if (x[i])
                p = i;
        m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return {p[5:0], frac};
    endfunction

    function automatic logic [PSNR_W-1:0] psnr_of(input logic [SSE_W-1:0] sse);
        logic [63:0] bits;
        logic [63:0] peak;
        logic [63:0] n;
        logic [63:0] ln;
        logic [63:0] ls;
        logic [63:0] q;
        bits = (bits_q > MAX_SAMPLE_BITS) ? 64'(MAX_SAMPLE_BITS) : 64'(bits_q);
        peak = (64'd1 << bits) - 64'd1;
        n = peak * peak * 64'(width_q) * 64'(height_q);
        if (sse == '0)
            return PSNR_CAP;
        if (n == '0)
            return '0;
        ln = 64'(log2_q16(n));
        ls = 64'(log2_q16(64'(sse)));
        if (ln <= ls)
            return '0;
        q = ((ln - ls) * 64'(TEN_LOG10_2_Q24) + (64'd1 << 31)) >> 32;
        return (q > 64'(PSNR_CAP)) ? PSNR_CAP : q[PSNR_W-1:0];
    endfunction

    task automatic take_request(input ppm_item_t it);
        logic [PIX_W-1:0] pa[LANES];
        logic [PIX_W-1:0] pb[LANES];
        int               lanes;
        logic [SQ_W-1:0]  sq;
        logic [PIX_W-1:0] diff;
        ppm_result_t      res;
        pa = '{it.pix_a0, it.pix_a1, it.pix_a2, it.pix_a3};
        pb = '{it.pix_b0, it.pix_b1, it.pix_b2, it.pix_b3};
        lanes = (it.lanes_valid > LANES) ? LANES : int'(it.lanes_valid);
        for (int k = 0; k < lanes; k++)
        begin
            diff = (pa[k] > pb[k]) ? pa[k] - pb[k] : pb[k] - pa[k];
            sq = SQ_W'(diff) * SQ_W'(diff);
            if (sse_sum > SSE_MAX - SSE_W'(sq))
                sse_sum = SSE_MAX;
            else
                sse_sum = sse_sum + SSE_W'(sq);
        end
        if (it.frame_end)
        begin
            res.psnr_q8 = psnr_of(sse_sum);
            res.sse_total = sse_sum;
            frame_results.push_back(res);
            sse_sum = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ppm_result_t want;
        if (!rst_n)
        begin
            width_q = 16'd1920;
            height_q = 16'd1080;
            bits_q = 5'd8;
            sse_sum = '0;
            fail_count = 0;
            frame_results.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (frame_results.size() == 0)
                begin
                    $error("result with no frame pending: psnr_q8 %0d sse_total %0d",
                           result.psnr_q8, result.sse_total);
                    fail_count++;
                end
                else
                begin
                    want = frame_results.pop_front();
                    if (result.psnr_q8 !== want.psnr_q8)
                    begin
                        $error("psnr_q8: expected %0d, actual %0d",
                               want.psnr_q8, result.psnr_q8);
                        fail_count++;
                    end
                    if (result.sse_total !== want.sse_total)
                    begin
                        $error("sse_total: expected %0d, actual %0d",
                               want.sse_total, result.sse_total);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_q = cfg_data;
                    REG_FRAME_HEIGHT: height_q = cfg_data;
                    REG_SAMPLE_BITS:  bits_q = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                take_request(item);
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top of the plane PSNR meter: stimulus, configuration phases and verdict.
module tb;
    import ppm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    ppm_item_t   item = '0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        result_valid;
    ppm_result_t result;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          burst_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    plane_psnr_meter u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .result(result)
    );

    ppm_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Holds the request until the block takes it, then maybe inserts a gap.
    task automatic send_request(input ppm_item_t it, input bit bursty);
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Drops start and lets the checker see the last request taken before waiting.
    task automatic drain_frames();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] bits);
        drain_frames();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_SAMPLE_BITS, bits);
    endtask

    function automatic ppm_item_t make_pair(input logic [15:0] a, input logic [15:0] b,
                                            input logic [2:0] lanes, input logic last);
        ppm_item_t it;
        it = '{a, a, a, a, b, b, b, b, lanes, last};
        return it;
    endfunction

    function automatic ppm_item_t random_item(input bit noisy, input int frame_odds);
        ppm_item_t        it;
        logic [15:0]      a[4];
        logic [15:0]      b[4];
        for (int k = 0; k < 4; k++)
        begin
            a[k] = $urandom_range(0, 65535);
            if (noisy)
                b[k] = $urandom_range(0, 65535);
            else
                b[k] = a[k] + 16'($urandom_range(0, 6)) - 16'd3;
        end
        it = '{a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3],
               ($urandom_range(0, 3) != 0) ? 3'd4 : 3'($urandom_range(0, 7)),
               ($urandom_range(1, frame_odds) == 1)};
        return it;
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset geometry: worst and best differences, odd lane counts.
        send_request(make_pair(16'hFFFF, 16'h0000, 3'd4, 1'b0), 1'b0);
        send_request(make_pair(16'h0000, 16'hFFFF, 3'd4, 1'b1), 1'b0);
        send_request(make_pair(16'h1234, 16'h1234, 3'd4, 1'b1), 1'b0);
        send_request(make_pair(16'h00FF, 16'h0000, 3'd0, 1'b1), 1'b0);
        send_request(make_pair(16'h0010, 16'h0000, 3'd7, 1'b1), 1'b0);
        send_request(make_pair(16'h0001, 16'h0000, 3'd1, 1'b1), 1'b0);
        send_request(make_pair(16'h0300, 16'h0000, 3'd5, 1'b1), 1'b0);

        // Tiny frame with a huge error drives the ratio below one.
        set_geometry(16'd1, 16'd1, 16'd8);
        send_request(make_pair(16'hFFFF, 16'h0000, 3'd4, 1'b1), 1'b0);
        send_request(make_pair(16'h0001, 16'h0000, 3'd1, 1'b1), 1'b0);
        // Largest frame and sample size.
        set_geometry(16'hFFFF, 16'hFFFF, 16'd16);
        send_request(make_pair(16'hFFFF, 16'h0000, 3'd4, 1'b1), 1'b0);
        send_request(make_pair(16'h0002, 16'h0000, 3'd2, 1'b1), 1'b0);
        // Zero sample bits, oversized sample bits and zero geometry.
        set_geometry(16'd640, 16'd480, 16'd0);
        send_request(make_pair(16'h0005, 16'h0001, 3'd3, 1'b1), 1'b0);
        set_geometry(16'd640, 16'd480, 16'hFFFF);
        send_request(make_pair(16'h0005, 16'h0001, 3'd3, 1'b1), 1'b0);
        set_geometry(16'd0, 16'd480, 16'd10);
        send_request(make_pair(16'h0005, 16'h0001, 3'd3, 1'b1), 1'b0);
        send_request(make_pair(16'h0005, 16'h0005, 3'd3, 1'b1), 1'b0);
        set_geometry(16'd64, 16'd0, 16'd12);
        send_request(make_pair(16'h0100, 16'h0000, 3'd4, 1'b1), 1'b0);

        // Random phases, each under its own geometry.
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 0)
                set_geometry(16'd1920, 16'd1080, 16'd8);
            else
                set_geometry(16'($urandom_range(0, 65535)) >> $urandom_range(0, 15),
                             16'($urandom_range(0, 65535)) >> $urandom_range(0, 15),
                             16'($urandom_range(0, 31)));
            for (int n = 0; n < 50; n++)
                send_request(random_item($urandom_range(0, 4) == 0, 8), phase % 3 != 2);
            send_request(random_item(1'b0, 1), 1'b0);
        end

        drain_frames();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
design/ppm_pkg.sv
design/ppm_lane.sv
design/ppm_log2.sv
design/plane_psnr_meter.sv
tb/ppm_checker.sv
tb/tb.sv
